// ===== src/ptmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptmt_pkg
// Shared types, widths and codes of the pending transaction match table.
// ----------------------------------------------------------------------------
package ptmt_pkg;

  localparam int TABLE_DEPTH_DEF  = 16;
  localparam int HANDLE_COUNT_DEF = 64;

  localparam int XID_W    = 32;
  localparam int IP_W     = 32;
  localparam int PORT_W   = 16;
  localparam int HANDLE_W = 6;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MATCH   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_HANDLE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MATCHED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RELEASED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_REL_OVERFLOW = 3'd6;

  typedef struct packed {
    logic [XID_W-1:0]  xid;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
  } key_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    key_t                key;
  } entry_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic add;          // shift toward the old end, new entry enters cell 0
    logic remove;       // close the gap at the first hit
    logic ignore_addr;  // compare on transaction id alone
  } ctl_t;

endpackage : ptmt_pkg
`default_nettype wire

// ===== src/ptmt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptmt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ptmt_ram
`default_nettype wire

// ===== src/ptmt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptmt_cell
// One table slot: holds an entry, compares it with the key and shifts.
// ----------------------------------------------------------------------------
module ptmt_cell
  import ptmt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctl_t                ctl,
  input  wire key_t                key,
  input  wire entry_t              left_in,
  input  wire entry_t              right_in,
  input  wire logic                hit_in,
  output entry_t                   entry_o,
  output logic                     hit_out,
  output logic      [HANDLE_W-1:0] sel_handle
);

  entry_t entry_r;
  logic   match;
  logic   first;

  always_comb begin
    match = entry_r.valid && (entry_r.key.xid == key.xid) &&
            (ctl.ignore_addr ||
             ((entry_r.key.ip == key.ip) && (entry_r.key.port == key.port)));
    first      = match && !hit_in;
    hit_out    = hit_in || match;
    sel_handle = first ? entry_r.handle : '0;
  end

  // Cells at or after the first hit pull their right neighbor in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (ctl.add) begin
      entry_r <= left_in;
    end else if (ctl.remove && hit_out) begin
      entry_r <= right_in;
    end
  end

  assign entry_o = entry_r;

endmodule : ptmt_cell
`default_nettype wire

// ===== src/pending_transaction_match_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pending_transaction_match_table
// Table of outstanding requests keyed by transaction id, address and port.
// ----------------------------------------------------------------------------
// A request is captured in the request registers, decided in the execute
// state and its result registered onto the out_ ports. No new request is
// taken until the last one is done, so that the registered read of the free
// handle stack memory can follow the stack count.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (rst_n, synchronous, active low) empties the table and the stack,
// restarts fresh handles at zero and clears ignore_address.
// ----------------------------------------------------------------------------
module pending_transaction_match_table
  import ptmt_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int HANDLE_COUNT = HANDLE_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Request channel.
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic        [REQ_W-1:0]    in_req_type,
  input  wire logic signed [XID_W-1:0]    in_xid,
  input  wire logic        [IP_W-1:0]     in_ip_addr,
  input  wire logic        [PORT_W-1:0]   in_port,
  input  wire logic        [HANDLE_W-1:0] in_handle_in,
  // Result channel.
  output logic                            out_valid,
  output logic             [STATUS_W-1:0] out_status,
  output logic             [HANDLE_W-1:0] out_handle_out,
  // Configuration: the ignore_address register.
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_wr_data
);

  // Stack count and fresh handle counter must hold HANDLE_COUNT itself.
  localparam int CNT_W  = $clog2(HANDLE_COUNT + 1);
  localparam int ADDR_W = $clog2(HANDLE_COUNT);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state_r;
  logic                  ignore_addr_r;
  logic [REQ_W-1:0]      req_type_r;
  key_t                  key_r;
  logic [HANDLE_W-1:0]   handle_in_r;
  logic [CNT_W-1:0]      stk_cnt_r;
  logic [CNT_W-1:0]      stk_cnt_nxt;
  logic [CNT_W-1:0]      fresh_r;
  logic [CNT_W-1:0]      fresh_nxt;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r;
  logic [STATUS_W-1:0]   status_nxt;
  logic [HANDLE_W-1:0]   handle_out_r;
  logic [HANDLE_W-1:0]   handle_out_nxt;

  // Chain signals.
  entry_t                cell_q   [TABLE_DEPTH];
  entry_t                cell_lft [TABLE_DEPTH];
  entry_t                cell_rgt [TABLE_DEPTH];
  logic                  hit_chain[TABLE_DEPTH+1];
  logic [HANDLE_W-1:0]   cell_sel [TABLE_DEPTH];
  logic [HANDLE_W-1:0]   hit_handle;
  entry_t                new_entry;
  ctl_t                  ctl;

  // Free handle stack memory.
  logic                  stk_we;
  logic [ADDR_W-1:0]     stk_waddr;
  logic [ADDR_W-1:0]     stk_raddr;
  logic [HANDLE_W-1:0]   stk_rdata;

  logic                  table_full;
  logic                  stk_empty;
  logic                  stk_full;
  logic                  fresh_ok;
  logic [HANDLE_W-1:0]   add_handle;

  // The read port always points at the top of the stack. The count changes
  // only at the end of a request, and the registered read of the new top word
  // is in place by the execute cycle of the next request.
  assign stk_raddr = ADDR_W'(stk_cnt_r - 1'b1);
  assign stk_waddr = stk_cnt_r[ADDR_W-1:0];

  ptmt_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (HANDLE_COUNT)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (handle_in_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Entries stay packed from cell 0 (newest) onward, so the table is full
  // exactly when the last cell holds an entry.
  assign table_full = cell_q[TABLE_DEPTH-1].valid;
  assign stk_empty  = (stk_cnt_r == '0);
  assign stk_full   = (stk_cnt_r >= CNT_W'(HANDLE_COUNT));
  assign fresh_ok   = (fresh_r < CNT_W'(HANDLE_COUNT));
  assign add_handle = stk_empty ? HANDLE_W'(fresh_r) : stk_rdata;

  assign new_entry.valid  = 1'b1;
  assign new_entry.handle = add_handle;
  assign new_entry.key    = key_r;

  // The first cell starts the hit chain; each cell passes on whether any
  // cell up to and including itself matched.
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_lft[i] = new_entry;
    end else begin : g_mid
      assign cell_lft[i] = cell_q[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign cell_rgt[i] = '0;
    end else begin : g_body
      assign cell_rgt[i] = cell_q[i+1];
    end

    ptmt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (key_r),
      .left_in    (cell_lft[i]),
      .right_in   (cell_rgt[i]),
      .hit_in     (hit_chain[i]),
      .entry_o    (cell_q[i]),
      .hit_out    (hit_chain[i+1]),
      .sel_handle (cell_sel[i])
    );
  end

  // Only the first hitting cell drives a nonzero handle.
  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_handle = hit_handle | cell_sel[i];
    end
  end

  // Decision for the request held in the request registers.
  always_comb begin
    ctl.add         = 1'b0;
    ctl.remove      = 1'b0;
    ctl.ignore_addr = ignore_addr_r;
    stk_we          = 1'b0;
    stk_cnt_nxt     = stk_cnt_r;
    fresh_nxt       = fresh_r;
    status_nxt      = ST_NO_MATCH;
    handle_out_nxt  = '0;

    if (state_r == S_EXEC) begin
      case (req_type_r)
        REQ_ADD: begin
          if (table_full) begin
            status_nxt = ST_FULL;
          end else if (!stk_empty) begin
            stk_cnt_nxt    = stk_cnt_r - 1'b1;
            ctl.add        = 1'b1;
            status_nxt     = ST_ADDED;
            handle_out_nxt = add_handle;
          end else if (fresh_ok) begin
            fresh_nxt      = fresh_r + 1'b1;
            ctl.add        = 1'b1;
            status_nxt     = ST_ADDED;
            handle_out_nxt = add_handle;
          end else begin
            status_nxt = ST_NO_HANDLE;
          end
        end
        REQ_MATCH: begin
          if (hit_chain[TABLE_DEPTH]) begin
            ctl.remove     = 1'b1;
            status_nxt     = ST_MATCHED;
            handle_out_nxt = hit_handle;
          end
        end
        REQ_RELEASE: begin
          if (stk_full) begin
            status_nxt = ST_REL_OVERFLOW;
          end else begin
            stk_we      = 1'b1;
            stk_cnt_nxt = stk_cnt_r + 1'b1;
            status_nxt  = ST_RELEASED;
          end
        end
        default: begin
          // The unused request type leaves everything as it is.
          status_nxt = ST_NO_MATCH;
        end
      endcase
    end
  end

  // Sequencer, counters and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ignore_addr_r <= 1'b0;
      stk_cnt_r     <= '0;
      fresh_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ignore_addr_r <= cfg_wr_data;
      end
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          stk_cnt_r   <= stk_cnt_nxt;
          fresh_r     <= fresh_nxt;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Request and result payload registers need no reset.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_type_r  <= in_req_type;
      key_r.xid   <= $unsigned(in_xid);
      key_r.ip    <= in_ip_addr;
      key_r.port  <= in_port;
      handle_in_r <= in_handle_in;
    end
    if (state_r == S_EXEC) begin
      status_r     <= status_nxt;
      handle_out_r <= handle_out_nxt;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_handle_out = handle_out_r;

endmodule : pending_transaction_match_table
`default_nettype wire

// ===== src/ptmt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptmt_checker
// Port-level checks of the pending transaction match table.
// ----------------------------------------------------------------------------
module ptmt_checker
  import ptmt_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic        [REQ_W-1:0]    in_req_type,
  input wire logic signed [XID_W-1:0]    in_xid,
  input wire logic        [IP_W-1:0]     in_ip_addr,
  input wire logic        [PORT_W-1:0]   in_port,
  input wire logic        [HANDLE_W-1:0] in_handle_in,
  input wire logic                       out_valid,
  input wire logic        [STATUS_W-1:0] out_status,
  input wire logic        [HANDLE_W-1:0] out_handle_out,
  input wire logic                       cfg_wr_en,
  input wire logic                       cfg_wr_data
);

  // Every accepted request is followed by its result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted request produced no result");

  // A result only ever closes a request that was being worked on.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  // No new request is taken while one is in progress.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("block not busy after accepting a request");

  // Only added and matched results carry a handle.
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ADDED && out_status != ST_MATCHED)
      |-> (out_handle_out == '0))
    else $error("handle given with a failing status");

  // Status code seven is never produced.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_REL_OVERFLOW))
    else $error("status code out of range");

endmodule : ptmt_checker

bind pending_transaction_match_table ptmt_checker u_ptmt_checker (.*);
`default_nettype wire

// ===== bench/match_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_table_checker
// Watches the request, result and register ports of the match table, keeps
// its own copy of the table, handle stack and register, and checks each
// result against the oldest outcome still owed.
// ----------------------------------------------------------------------------
module match_table_checker
  import ptmt_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire logic        [REQ_W-1:0]    in_req_type,
  input  wire logic signed [XID_W-1:0]    in_xid,
  input  wire logic        [IP_W-1:0]     in_ip_addr,
  input  wire logic        [PORT_W-1:0]   in_port,
  input  wire logic        [HANDLE_W-1:0] in_handle_in,
  input  wire logic                       out_valid,
  input  wire logic        [STATUS_W-1:0] out_status,
  input  wire logic        [HANDLE_W-1:0] out_handle_out,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_wr_data,
  output int unsigned                     fault_count,
  output int unsigned                     results_owed
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
  } outcome_t;

  // Slot 0 holds the newest entry; valid entries are always packed low.
  entry_t              slots [TABLE_DEPTH_DEF];
  logic [HANDLE_W-1:0] spare_stack [HANDLE_COUNT_DEF];
  int unsigned         spare_depth;
  int unsigned         fresh_next;
  logic                ignore_addr;
  outcome_t            owed [$];
  int unsigned         faults;

  // Applies one request to the table copy and returns the outcome it earns.
  function automatic outcome_t apply_request(input logic [REQ_W-1:0]    kind,
                                             input key_t                key,
                                             input logic [HANDLE_W-1:0] given);
    outcome_t            res;
    logic [HANDLE_W-1:0] h;
    int                  used;
    int                  hit;
    int                  i;
    res.status = ST_NO_MATCH;
    res.handle = '0;
    used = 0;
    for (i = 0; i < TABLE_DEPTH_DEF; i++)
      if (slots[i].valid) used++;
    case (kind)
      REQ_ADD: begin
        // A full table is reported before the handle supply is looked at.
        if (used >= TABLE_DEPTH_DEF) begin
          res.status = ST_FULL;
        end else if (spare_depth == 0 && fresh_next >= HANDLE_COUNT_DEF) begin
          res.status = ST_NO_HANDLE;
        end else begin
          if (spare_depth > 0) begin
            spare_depth--;
            h = spare_stack[spare_depth];
          end else begin
            h = HANDLE_W'(fresh_next);
            fresh_next++;
          end
          for (i = TABLE_DEPTH_DEF - 1; i > 0; i--) slots[i] = slots[i-1];
          slots[0].valid  = 1'b1;
          slots[0].handle = h;
          slots[0].key    = key;
          res.status = ST_ADDED;
          res.handle = h;
        end
      end
      REQ_MATCH: begin
        hit = -1;
        for (i = 0; i < TABLE_DEPTH_DEF && hit < 0; i++)
          if (slots[i].valid && slots[i].key.xid == key.xid &&
              (ignore_addr || (slots[i].key.ip == key.ip &&
                               slots[i].key.port == key.port)))
            hit = i;
        if (hit >= 0) begin
          res.status = ST_MATCHED;
          res.handle = slots[hit].handle;
          for (i = hit; i < TABLE_DEPTH_DEF - 1; i++) slots[i] = slots[i+1];
          slots[TABLE_DEPTH_DEF-1].valid = 1'b0;
        end
      end
      REQ_RELEASE: begin
        if (spare_depth >= HANDLE_COUNT_DEF) begin
          res.status = ST_REL_OVERFLOW;
        end else begin
          spare_stack[spare_depth] = given;
          spare_depth++;
          res.status = ST_RELEASED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    key_t     key;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH_DEF; i++) slots[i] = '0;
      spare_depth = 0;
      fresh_next  = 0;
      ignore_addr = 1'b0;
      owed.delete();
    end else begin
      // A result never comes in the cycle of its own request, so results are
      // checked before the request of this edge is added.
      if (out_valid) begin
        if (owed.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("[%0t] result with nothing owed: status %0d handle %0d",
                     $time, out_status, out_handle_out);
        end else begin
          want = owed.pop_front();
          if (want.status !== out_status || want.handle !== out_handle_out) begin
            faults++;
            if (faults <= 10)
              $display("[%0t] wrong result: expected status %0d handle %0d, got status %0d handle %0d",
                       $time, want.status, want.handle, out_status, out_handle_out);
          end
        end
      end
      if (cfg_wr_en) ignore_addr = cfg_wr_data;
      if (start && !busy) begin
        key.xid  = in_xid;
        key.ip   = in_ip_addr;
        key.port = in_port;
        owed.push_back(apply_request(in_req_type, key, in_handle_in));
      end
    end
    fault_count  <= faults;
    results_owed <= owed.size();
  end

endmodule : match_table_checker

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the pending transaction match
// table and gives the verdict; the checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import ptmt_pkg::*;

  // The request type that the block leaves unused; it must answer no match.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic        [REQ_W-1:0]    in_req_type;
  logic signed [XID_W-1:0]    in_xid;
  logic        [IP_W-1:0]     in_ip_addr;
  logic        [PORT_W-1:0]   in_port;
  logic        [HANDLE_W-1:0] in_handle_in;
  logic                       out_valid;
  logic        [STATUS_W-1:0] out_status;
  logic        [HANDLE_W-1:0] out_handle_out;
  logic                       cfg_wr_en;
  logic                       cfg_wr_data;
  int unsigned                fault_count;
  int unsigned                results_owed;

  // Keys of recent adds, so that most matches can find a live entry.
  key_t recent_keys [$];
  int   sent_count;
  bit   no_gaps;
  bit   drain_overrun;

  always #2 clk = ~clk;

  pending_transaction_match_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_xid         (in_xid),
    .in_ip_addr     (in_ip_addr),
    .in_port        (in_port),
    .in_handle_in   (in_handle_in),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_handle_out (out_handle_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  match_table_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_xid         (in_xid),
    .in_ip_addr     (in_ip_addr),
    .in_port        (in_port),
    .in_handle_in   (in_handle_in),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_handle_out (out_handle_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fault_count    (fault_count),
    .results_owed   (results_owed)
  );

  function automatic key_t make_key(input logic [XID_W-1:0]  xid,
                                    input logic [IP_W-1:0]   ip,
                                    input logic [PORT_W-1:0] port);
    key_t k;
    k.xid  = xid;
    k.ip   = ip;
    k.port = port;
    return k;
  endfunction

  // A narrow key draws from a handful of ids, addresses and ports, so that
  // several live entries share an id or a whole key and the newest one has
  // to win. A wide key is fully random.
  function automatic key_t random_key(input bit narrow);
    if (narrow)
      return make_key(XID_W'($urandom_range(0, 5)) - XID_W'(3),
                      32'hC0A8_0000 | IP_W'($urandom_range(0, 2)),
                      PORT_W'($urandom_range(0, 2)));
    return make_key($urandom, $urandom, PORT_W'($urandom_range(0, 65535)));
  endfunction

  // Sends one request: an optional idle gap with start low, then start held
  // high with the payload until the block takes it. Start is left high after
  // the accepting edge; the next falling edge either lowers it or carries the
  // next request, never both.
  task automatic issue(input logic [REQ_W-1:0]    kind,
                       input key_t                key,
                       input logic [HANDLE_W-1:0] handle);
    int gap;
    // Every forty requests, decide whether the next stretch runs back to back.
    if (sent_count % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_req_type  <= kind;
    in_xid       <= key.xid;
    in_ip_addr   <= key.ip;
    in_port      <= key.port;
    in_handle_in <= handle;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    if (kind == REQ_ADD) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
  endtask

  // Lowers start and waits until every owed result has come back. The wait
  // is bounded; running over it counts against the verdict.
  task automatic settle();
    int waited;
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (results_owed != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    if (results_owed != 0) drain_overrun = 1'b1;
    // Each request ends in exactly one result, so the block is quiet by now;
    // the wait below is only a margin all the same.
    repeat (3) @(posedge clk);
  endtask

  // The register is only written with the table idle.
  task automatic set_ignore(input logic value);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // A mixed stretch of traffic. The weights are percentages of adds, matches
  // and releases; what is left over goes to the unused request type. Most
  // matches reuse a recent key, a quarter of those with one address or port
  // bit flipped, which misses its own entry unless the address is ignored.
  task automatic run_mixed(input int count, input int add_w, input int match_w,
                           input int release_w, input bit narrow);
    int   roll;
    int   bit_sel;
    key_t key;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      key  = random_key(narrow);
      if (roll < add_w) begin
        issue(REQ_ADD, key, HANDLE_W'($urandom_range(0, 63)));
      end else if (roll < add_w + match_w) begin
        if (recent_keys.size() > 0 && $urandom_range(0, 99) < 70) begin
          key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
          if ($urandom_range(0, 3) == 0) begin
            bit_sel = $urandom_range(0, IP_W + PORT_W - 1);
            if (bit_sel < IP_W) key.ip[bit_sel] = ~key.ip[bit_sel];
            else                key.port[bit_sel - IP_W] = ~key.port[bit_sel - IP_W];
          end
        end
        issue(REQ_MATCH, key, HANDLE_W'($urandom_range(0, 63)));
      end else if (roll < add_w + match_w + release_w) begin
        issue(REQ_RELEASE, key, HANDLE_W'($urandom_range(0, 63)));
      end else begin
        issue(REQ_UNUSED, key, HANDLE_W'($urandom_range(0, 63)));
      end
    end
  endtask

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    key_t key;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req_type  = REQ_ADD;
    in_xid       = '0;
    in_ip_addr   = '0;
    in_port      = '0;
    in_handle_in = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    sent_count   = 0;
    no_gaps      = 1'b0;
    drain_overrun = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, address compared. Two entries share the top id with
    // different addresses; the match must pick the one whose address fits,
    // not simply the newest, and a port mismatch must miss.
    issue(REQ_ADD, make_key(32'h8000_0000, 32'h0000_0000, 16'h0000), '0);
    issue(REQ_ADD, make_key(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), '0);
    issue(REQ_ADD, make_key(32'h7FFF_FFFF, 32'h0A00_0001, 16'd53), '0);
    issue(REQ_MATCH, make_key(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), '0);
    issue(REQ_MATCH, make_key(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0000), '0);
    // Releases are not checked: the top handle and a handle still in use
    // both go onto the stack, and the next add takes the last one pushed.
    issue(REQ_RELEASE, make_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 6'd63);
    issue(REQ_RELEASE, make_key(32'h0, 32'h0, 16'h0), 6'd0);
    issue(REQ_ADD, make_key(32'h0000_0001, 32'h7F00_0001, 16'd80), '0);
    issue(REQ_UNUSED, make_key(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF), 6'd63);

    // Address ignored: a match on the id alone takes the newest such entry.
    set_ignore(1'b1);
    issue(REQ_ADD, make_key(32'h7FFF_FFFF, 32'h0000_0001, 16'd1), '0);
    issue(REQ_MATCH, make_key(32'h7FFF_FFFF, 32'h0000_0000, 16'd0), '0);
    // Fill the table to the last slot, then one more add must report it full.
    for (int i = 0; i < 14; i++)
      issue(REQ_ADD, make_key(XID_W'(i + 16), $urandom, PORT_W'($urandom_range(0, 65535))),
            '0);

    // Wide random traffic with the address compared.
    set_ignore(1'b0);
    run_mixed(350, 40, 35, 20, 1'b0);

    // Use up the handle supply: every add is matched away at once and
    // nothing is released, so the stack drains, the fresh handles run out and
    // later adds report no handle left.
    settle();
    recent_keys.delete();
    repeat (150) begin
      key = random_key(1'b0);
      issue(REQ_ADD, key, HANDLE_W'($urandom_range(0, 63)));
      issue(REQ_MATCH, key, HANDLE_W'($urandom_range(0, 63)));
    end

    // Push more handles than the stack holds, so that releases overflow.
    repeat (70) issue(REQ_RELEASE, random_key(1'b0), HANDLE_W'($urandom_range(0, 63)));

    // Crowded keys, first matched on the id alone, then on the whole key.
    set_ignore(1'b1);
    run_mixed(450, 35, 30, 30, 1'b1);
    set_ignore(1'b0);
    run_mixed(450, 35, 30, 30, 1'b1);

    // Noise: every request type evenly, wide random keys; matches still mostly reuse recent keys.
    set_ignore(1'($urandom_range(0, 1)));
    run_mixed(150, 25, 25, 25, 1'b0);

    settle();
    if (fault_count == 0 && results_owed == 0 && !drain_overrun)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule : testbench

// ===== filelist.f =====
src/ptmt_pkg.sv
src/ptmt_ram.sv
src/ptmt_cell.sv
src/pending_transaction_match_table.sv
src/ptmt_checker.sv
bench/match_table_checker.sv
bench/testbench.sv
